// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/rrot_pkg.sv =====
`timescale 1ns / 1ps
package rrot_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int ADDR_WIDTH  = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ENTRIES_W   = 7;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_BASE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_SIZE = 1'd1;

    localparam logic FUNC_RESERVE = 1'b0;
    localparam logic FUNC_CHECK   = 1'b1;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_NOMEM = 1'b1;

    typedef struct packed {
        logic             capture;
        logic             reserve;
        logic             rd_en;
        logic [IDX_W-1:0] rd_idx;
        logic             chk_done;
        logic             chk_status;
    } t_ctl_cmd;

    typedef struct packed {
        logic             hit;
        logic [CNT_W-1:0] count;
    } t_dp_stat;

endpackage

// ===== rtl/rrot_datapath.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rrot_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  rrot_pkg::t_ctl_cmd                i_cmd,
    output rrot_pkg::t_dp_stat                o_stat,
    input  logic [rrot_pkg::ADDR_WIDTH-1:0]   i_range_start,
    input  logic [rrot_pkg::ADDR_WIDTH-1:0]   i_range_size,
    input  logic                              i_cfg_valid,
    input  logic [rrot_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rrot_pkg::ADDR_WIDTH-1:0]   i_cfg_data,
    output logic                              o_status,
    output logic [rrot_pkg::ENTRIES_W-1:0]    o_entries_used
);

    logic [rrot_pkg::ADDR_WIDTH-1:0] r_kbase;
    logic [rrot_pkg::ADDR_WIDTH-1:0] r_ksize;
    logic [rrot_pkg::ADDR_WIDTH-1:0] mem_base [rrot_pkg::TABLE_DEPTH];
    logic [rrot_pkg::ADDR_WIDTH-1:0] mem_size [rrot_pkg::TABLE_DEPTH];
    logic [rrot_pkg::ADDR_WIDTH-1:0] r_start;
    logic [rrot_pkg::ADDR_WIDTH-1:0] r_len;
    logic [rrot_pkg::ADDR_WIDTH:0]   r_end_q;
    logic [rrot_pkg::ADDR_WIDTH-1:0] r_rd_base;
    logic [rrot_pkg::ADDR_WIDTH-1:0] r_rd_size;
    logic                            r_rd_zero;
    logic [rrot_pkg::CNT_W-1:0]      r_count;
    logic [rrot_pkg::CNT_W-1:0]      r_out_cnt;
    logic                            r_status;
    logic                            full;
    logic [rrot_pkg::ADDR_WIDTH-1:0] cmp_base;
    logic [rrot_pkg::ADDR_WIDTH-1:0] cmp_size;
    logic [rrot_pkg::ADDR_WIDTH:0]   end_b;
    logic                            hit;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kbase <= '0;
            r_ksize <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                rrot_pkg::CFG_KERNEL_BASE: r_kbase <= i_cfg_data;
                rrot_pkg::CFG_KERNEL_SIZE: r_ksize <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // range table, one write port and one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.reserve && !full) begin
            mem_base[r_count[rrot_pkg::IDX_W-1:0]] <= r_start;
            mem_size[r_count[rrot_pkg::IDX_W-1:0]] <= r_len;
        end
        if (i_cmd.rd_en) begin
            r_rd_base <= mem_base[i_cmd.rd_idx];
            r_rd_size <= mem_size[i_cmd.rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_start <= i_range_start;
            r_len   <= i_range_size;
            r_end_q <= {1'b0, i_range_start} + {1'b0, i_range_size};
        end
        if (i_cmd.rd_en) begin
            r_rd_zero <= (i_cmd.rd_idx == '0);
        end
    end

    assign full     = (r_count == rrot_pkg::CNT_W'(rrot_pkg::TABLE_DEPTH));
    assign cmp_base = r_rd_zero ? r_kbase : r_rd_base;
    assign cmp_size = r_rd_zero ? r_ksize : r_rd_size;
    assign end_b    = {1'b0, cmp_base} + {1'b0, cmp_size};
    assign hit      = ((cmp_base <= r_start) && ({1'b0, r_start} < end_b))
                   || ((r_start <= cmp_base) && ({1'b0, cmp_base} < r_end_q));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= rrot_pkg::CNT_W'(1);
            r_out_cnt <= rrot_pkg::CNT_W'(1);
            r_status  <= rrot_pkg::STATUS_OK;
        end else if (i_cmd.reserve) begin
            if (full) begin
                r_status  <= rrot_pkg::STATUS_NOMEM;
                r_out_cnt <= r_count;
            end else begin
                r_status  <= rrot_pkg::STATUS_OK;
                r_count   <= r_count + rrot_pkg::CNT_W'(1);
                r_out_cnt <= r_count + rrot_pkg::CNT_W'(1);
            end
        end else if (i_cmd.chk_done) begin
            r_status  <= i_cmd.chk_status;
            r_out_cnt <= r_count;
        end
    end

    assign o_stat.hit     = hit;
    assign o_stat.count   = r_count;
    assign o_status       = r_status;
    assign o_entries_used = rrot_pkg::ENTRIES_W'(r_out_cnt);

    `ASSERT_IMPLY(a_count_range, i_clk, i_rst_n, 1'b1,
        (r_count != '0) && (r_count <= rrot_pkg::CNT_W'(rrot_pkg::TABLE_DEPTH)))
    `ASSERT_NEXT(a_full_holds, i_clk, i_rst_n, i_cmd.reserve && full,
        (r_count == $past(r_count)) && (r_status == rrot_pkg::STATUS_NOMEM))

endmodule

// ===== rtl/rrot_ctrl.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rrot_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  logic               i_func,
    output logic               busy,
    output logic               o_strobe,
    output rrot_pkg::t_ctl_cmd o_cmd,
    input  rrot_pkg::t_dp_stat i_stat
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RES,
        S_CHK
    } t_state;

    t_state                      r_state;
    logic [rrot_pkg::IDX_W-1:0]  r_idx;
    logic                        r_cmp_vld;
    logic                        r_cmp_last;
    logic                        r_iss_done;
    logic                        r_strobe;
    logic                        finish;
    logic                        last_iss;

    assign last_iss = ((rrot_pkg::CNT_W'(r_idx) + rrot_pkg::CNT_W'(1)) == i_stat.count);
    assign finish   = (r_state == S_CHK) && r_cmp_vld && (i_stat.hit || r_cmp_last);

    always_comb begin
        o_cmd            = '0;
        o_cmd.capture    = start && (r_state == S_IDLE);
        o_cmd.reserve    = (r_state == S_RES);
        o_cmd.rd_en      = (r_state == S_CHK) && !r_iss_done;
        o_cmd.rd_idx     = r_idx;
        o_cmd.chk_done   = finish;
        o_cmd.chk_status = i_stat.hit ? rrot_pkg::STATUS_NOMEM : rrot_pkg::STATUS_OK;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_idx      <= '0;
            r_cmp_vld  <= 1'b0;
            r_cmp_last <= 1'b0;
            r_iss_done <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_idx      <= '0;
                        r_cmp_vld  <= 1'b0;
                        r_cmp_last <= 1'b0;
                        r_iss_done <= 1'b0;
                        r_state    <= (i_func == rrot_pkg::FUNC_CHECK) ? S_CHK : S_RES;
                    end
                end
                S_RES: begin
                    r_strobe <= 1'b1;
                    r_state  <= S_IDLE;
                end
                S_CHK: begin
                    if (finish) begin
                        r_strobe <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_cmp_vld <= o_cmd.rd_en;
                        if (o_cmd.rd_en) begin
                            r_idx      <= r_idx + rrot_pkg::IDX_W'(1);
                            r_cmp_last <= last_iss;
                            r_iss_done <= last_iss;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;

    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    `ASSERT_IMPLY(a_strobe_after_work, i_clk, i_rst_n, r_strobe,
        $past(r_state) != S_IDLE)
    `ASSERT_IMPLY(a_read_in_use, i_clk, i_rst_n, o_cmd.rd_en,
        rrot_pkg::CNT_W'(r_idx) < i_stat.count)

endmodule

// ===== rtl/reserved_range_overlap_table_core.sv =====
`timescale 1ns / 1ps
// Reserved address range table. Entry zero is the kernel region taken live from configuration
// registers 0 (base) and 1 (size); reserves append ranges after it, up to 64 entries. A reserve
// passes from start through the reserve state to the registered result strobe. A check walks the
// entries in use through the table's single registered read port, one entry per cycle, and stops
// at the first overlap. Busy is high from the cycle after start until the result strobe; a new
// start may be given in the strobe cycle. Each result is shown for one cycle only and the
// receiver cannot stall it.
module reserved_range_overlap_table_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_func,
    input  logic [rrot_pkg::ADDR_WIDTH-1:0]   i_range_start,
    input  logic [rrot_pkg::ADDR_WIDTH-1:0]   i_range_size,
    output logic                              o_strobe,
    output logic                              o_status,
    output logic [rrot_pkg::ENTRIES_W-1:0]    o_entries_used,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rrot_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rrot_pkg::ADDR_WIDTH-1:0]   i_cfg_data
);

    rrot_pkg::t_ctl_cmd cmd;
    rrot_pkg::t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    rrot_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_func   (i_func),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_cmd    (cmd),
        .i_stat   (stat)
    );

    rrot_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_range_start  (i_range_start),
        .i_range_size   (i_range_size),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_status       (o_status),
        .o_entries_used (o_entries_used)
    );

endmodule

// ===== tb/tb_reserved_range_overlap_table_core.sv =====
`timescale 1ns / 1ps
module tb_reserved_range_overlap_table_core;

    localparam int AW = rrot_pkg::ADDR_WIDTH;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 70;
    localparam logic [AW-1:0] WINDOW_BASE = 32'h1000_0000;

    typedef struct packed {
        logic                           status;
        logic [rrot_pkg::ENTRIES_W-1:0] entries_used;
    } t_reply;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           start;
    logic                           busy;
    logic                           i_func;
    logic [AW-1:0]                  i_range_start;
    logic [AW-1:0]                  i_range_size;
    logic                           o_strobe;
    logic                           o_status;
    logic [rrot_pkg::ENTRIES_W-1:0] o_entries_used;
    logic                           i_cfg_valid;
    logic                           o_cfg_ready;
    logic [rrot_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [AW-1:0]                  i_cfg_data;

    logic [AW-1:0] region_base_tab [rrot_pkg::TABLE_DEPTH];
    logic [AW-1:0] region_size_tab [rrot_pkg::TABLE_DEPTH];
    int unsigned   entries_in_use;
    t_reply        pending_replies[$];
    t_reply        due_reply;

    int unsigned idle_pct;
    int unsigned err_count;
    int unsigned stall_cycles;
    int unsigned n_reserves, n_checks, n_overlaps, n_full_rejects, n_cfg_writes;

    reserved_range_overlap_table_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_func         (i_func),
        .i_range_start  (i_range_start),
        .i_range_size   (i_range_size),
        .o_strobe       (o_strobe),
        .o_status       (o_status),
        .o_entries_used (o_entries_used),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // end sums one bit wider so a range running past the top never wraps
    function automatic bit ranges_overlap(input logic [AW-1:0] base, input logic [AW-1:0] size,
                                          input logic [AW-1:0] qs, input logic [AW-1:0] ql);
        logic [AW:0] entry_end;
        logic [AW:0] query_end;
        entry_end = {1'b0, base} + {1'b0, size};
        query_end = {1'b0, qs} + {1'b0, ql};
        return ((base <= qs) && ({1'b0, qs} < entry_end)) ||
               ((qs <= base) && ({1'b0, base} < query_end));
    endfunction

    function automatic t_reply predict_table_reply(input logic func, input logic [AW-1:0] rs,
                                                   input logic [AW-1:0] rl);
        t_reply r;
        r.status = rrot_pkg::STATUS_OK;
        if (func == rrot_pkg::FUNC_RESERVE) begin
            if (entries_in_use >= rrot_pkg::TABLE_DEPTH) begin
                r.status = rrot_pkg::STATUS_NOMEM;
            end else begin
                region_base_tab[entries_in_use] = rs;
                region_size_tab[entries_in_use] = rl;
                entries_in_use++;
            end
        end else begin
            for (int unsigned i = 0; i < entries_in_use; i++) begin
                if (ranges_overlap(region_base_tab[i], region_size_tab[i], rs, rl)) begin
                    r.status = rrot_pkg::STATUS_NOMEM;
                    break;
                end
            end
        end
        r.entries_used = entries_in_use[rrot_pkg::ENTRIES_W-1:0];
        return r;
    endfunction

    task automatic send_item(input logic func, input logic [AW-1:0] rs, input logic [AW-1:0] rl);
        t_reply r;
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        start         <= 1'b1;
        i_func        <= func;
        i_range_start <= rs;
        i_range_size  <= rl;
        do @(posedge i_clk); while (busy);
        r = predict_table_reply(func, rs, rl);
        pending_replies.push_back(r);
        if (func == rrot_pkg::FUNC_RESERVE) begin
            n_reserves++;
            if (r.status == rrot_pkg::STATUS_NOMEM) n_full_rejects++;
        end else begin
            n_checks++;
            if (r.status == rrot_pkg::STATUS_NOMEM) n_overlaps++;
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_replies.size() != 0);
    endtask

    task automatic cfg_write(input logic [rrot_pkg::CFG_IDX_W-1:0] idx,
                             input logic [AW-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == rrot_pkg::CFG_KERNEL_BASE) region_base_tab[0] = data;
        else region_size_tab[0] = data;
        n_cfg_writes++;
    endtask

    task automatic set_kernel(input logic [AW-1:0] base, input logic [AW-1:0] size);
        wait_drained();
        cfg_write(rrot_pkg::CFG_KERNEL_BASE, base);
        cfg_write(rrot_pkg::CFG_KERNEL_SIZE, size);
        i_cfg_valid <= 1'b0;
    endtask

    // mostly small ranges in a sparse window, a few spanning the top or anywhere
    task automatic pick_reserve(output logic [AW-1:0] rs, output logic [AW-1:0] rl);
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 8) begin
            rs = 32'hF000_0000 | $urandom_range(0, 32'h0FFF_FFFF);
            rl = $urandom();
        end else if (roll < 16) begin
            rs = $urandom();
            rl = $urandom_range(0, 255);
        end else begin
            rs = WINDOW_BASE + ($urandom_range(0, 255) << 16) + $urandom_range(0, 32'hFFF);
            rl = (roll < 24) ? '0 : $urandom_range(1, 32'h8000);
        end
    endtask

    task automatic pick_query(output logic [AW-1:0] rs, output logic [AW-1:0] rl);
        int unsigned roll;
        int unsigned idx;
        logic [AW-1:0] b;
        logic [AW-1:0] sz;
        roll = $urandom_range(99);
        if (roll < 10) begin
            rs = $urandom();
            rl = $urandom();
        end else if (roll < 25) begin
            rs = WINDOW_BASE + $urandom_range(0, 32'h00FF_FFFF);
            rl = $urandom_range(0, 32'h2_0000);
        end else begin
            idx = $urandom_range(0, entries_in_use - 1);
            b   = region_base_tab[idx];
            sz  = region_size_tab[idx];
            rl  = $urandom_range(0, 3);
            case ($urandom_range(0, 4))
                0: begin
                    rs = b - $urandom_range(1, 32'h40);
                    rl = $urandom_range(0, 32'h80);
                end
                1: rs = b;
                2: rs = b + sz - 1;
                3: rs = b + sz;
                default: begin
                    rs = b + ($urandom() & sz);
                    rl = $urandom_range(0, 32'h1000);
                end
            endcase
        end
    endtask

    task automatic test_empty_table();
        send_item(rrot_pkg::FUNC_CHECK, 32'h0, 32'h0);
        send_item(rrot_pkg::FUNC_CHECK, 32'h0, 32'h1);
        send_item(rrot_pkg::FUNC_CHECK, 32'h1, 32'hFFFF_FFFF);
    endtask

    task automatic test_directed_overlap();
        send_item(rrot_pkg::FUNC_RESERVE, 32'h1000_0000, 32'h100);
        send_item(rrot_pkg::FUNC_RESERVE, 32'h1000_1000, 32'h0);
        send_item(rrot_pkg::FUNC_RESERVE, 32'hFFFF_FF00, 32'h200);
        send_item(rrot_pkg::FUNC_CHECK, 32'h1000_0080, 32'h10);
        send_item(rrot_pkg::FUNC_CHECK, 32'h0FFF_FF00, 32'h101);
        send_item(rrot_pkg::FUNC_CHECK, 32'h0FFF_FF00, 32'h100);
        send_item(rrot_pkg::FUNC_CHECK, 32'h1000_0100, 32'h10);
        // zero-size entry: only reachable through a query that holds its base
        send_item(rrot_pkg::FUNC_CHECK, 32'h1000_1000, 32'h0);
        send_item(rrot_pkg::FUNC_CHECK, 32'h1000_1000, 32'h1);
        send_item(rrot_pkg::FUNC_CHECK, 32'h1000_0FFF, 32'h1);
        send_item(rrot_pkg::FUNC_CHECK, 32'h1000_0FFF, 32'h2);
        // entry ending past the top of the address space
        send_item(rrot_pkg::FUNC_CHECK, 32'hFFFF_FFFF, 32'h0);
        send_item(rrot_pkg::FUNC_CHECK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(rrot_pkg::FUNC_CHECK, 32'h0, 32'h0);
        send_item(rrot_pkg::FUNC_CHECK, 32'h0, 32'hFFFF_FFFF);
        send_item(rrot_pkg::FUNC_CHECK, 32'h0800_0800, 32'h4);
        send_item(rrot_pkg::FUNC_CHECK, 32'h0800_1000, 32'h4);
    endtask

    task automatic test_random_traffic(input int unsigned count, input int unsigned pct);
        logic [AW-1:0] rs;
        logic [AW-1:0] rl;
        idle_pct = pct;
        for (int unsigned n = 0; n < count; n++) begin
            if ($urandom_range(99) < 15) begin
                pick_reserve(rs, rl);
                send_item(rrot_pkg::FUNC_RESERVE, rs, rl);
            end else begin
                pick_query(rs, rl);
                send_item(rrot_pkg::FUNC_CHECK, rs, rl);
            end
            if ($urandom_range(99) == 0) wait_drained();
        end
    endtask

    task automatic test_table_full();
        logic [AW-1:0] rs;
        logic [AW-1:0] rl;
        while (entries_in_use < rrot_pkg::TABLE_DEPTH) begin
            pick_reserve(rs, rl);
            send_item(rrot_pkg::FUNC_RESERVE, rs, rl);
        end
        send_item(rrot_pkg::FUNC_RESERVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(rrot_pkg::FUNC_RESERVE, 32'h0, 32'h0);
        send_item(rrot_pkg::FUNC_CHECK, 32'h1FFF_0000, 32'h10);
    endtask

    task automatic test_config_extremes();
        set_kernel(32'h0, 32'hFFFF_FFFF);
        send_item(rrot_pkg::FUNC_CHECK, 32'h0, 32'h0);
        send_item(rrot_pkg::FUNC_CHECK, 32'hFFFF_FFFE, 32'h0);
        send_item(rrot_pkg::FUNC_CHECK, 32'hFFFF_FFFF, 32'h0);
        set_kernel(32'hFFFF_FFFF, 32'h0);
        send_item(rrot_pkg::FUNC_CHECK, 32'hFFFF_FFFF, 32'h0);
        send_item(rrot_pkg::FUNC_CHECK, 32'hFFFF_FFFE, 32'h1);
        send_item(rrot_pkg::FUNC_CHECK, 32'hFFFF_FFFE, 32'h2);
        send_item(rrot_pkg::FUNC_CHECK, 32'h0, 32'h1);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (pending_replies.size() == 0) begin
                $error("unexpected result: status %0d entries_used %0d", o_status,
                       o_entries_used);
                err_count++;
            end else begin
                due_reply = pending_replies.pop_front();
                if (o_status !== due_reply.status) begin
                    $error("status: expected %0d, got %0d", due_reply.status, o_status);
                    err_count++;
                end
                if (o_entries_used !== due_reply.entries_used) begin
                    $error("entries_used: expected %0d, got %0d", due_reply.entries_used,
                           o_entries_used);
                    err_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_strobe || (i_cfg_valid && o_cfg_ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("timeout: no request or result for %0d cycles", STALL_LIMIT);
                $display("[reserved_range_overlap_table_core] ERROR");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        start         <= 1'b0;
        i_func        <= rrot_pkg::FUNC_RESERVE;
        i_range_start <= '0;
        i_range_size  <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= rrot_pkg::CFG_KERNEL_BASE;
        i_cfg_data    <= '0;
        stall_cycles  <= 0;
        idle_pct       = 0;
        err_count      = 0;
        n_reserves     = 0;
        n_checks       = 0;
        n_overlaps     = 0;
        n_full_rejects = 0;
        n_cfg_writes   = 0;
        entries_in_use = 1;
        region_base_tab[0] = '0;
        region_size_tab[0] = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_table();
        set_kernel(32'h0800_0000, 32'h1000);
        test_directed_overlap();
        test_random_traffic(300, 0);
        set_kernel(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        test_random_traffic(300, 69);
        test_table_full();
        test_config_extremes();
        set_kernel(WINDOW_BASE + $urandom_range(0, 32'h00FF_FFFF), $urandom_range(0, 32'h10_0000));
        test_random_traffic(300, 32);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_replies.size() != 0) begin
            $error("%0d results never arrived", pending_replies.size());
            err_count++;
        end
        $display("covered %0d reserves (%0d refused on a full table), %0d checks (%0d overlaps)",
                 n_reserves, n_full_rejects, n_checks, n_overlaps);
        $display("across %0d kernel region writes, %0d mismatches", n_cfg_writes, err_count);
        if (err_count == 0) begin
            $display("[reserved_range_overlap_table_core] OK");
        end else begin
            $display("[reserved_range_overlap_table_core] ERROR");
        end
        $finish;
    end

endmodule
